/* sv/lru_key_value_cache_core_defines.svh */
// ----------------------------------------------------------------------------
// lru key/value cache assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// same-cycle implication
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// beat types, operation codes and defaults for the lru key/value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  // fixed field widths of the beats and of the capacity value
  localparam int FIELD_W = 32;
  localparam int CAP_W   = 5;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  // parameter defaults
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF  = 32;

  // input beat
  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] lookup_key;
    logic [FIELD_W-1:0] write_value;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] read_value;
    logic               evicted;
    logic [FIELD_W-1:0] evicted_key;
  } out_item_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic go;       // operation accepted this cycle
    logic ins_all;  // put of a new key: whole row moves down one place
    logic put_hit;  // put of a present key
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/lkvc_cell.sv */
// ----------------------------------------------------------------------------
// lkvc_cell
// one place of the recency-ordered row: holds a key and a value, compares
// the lookup key and takes its upper neighbour's entry when the row moves
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_cell #(
  parameter int KW = 32,
  parameter int VW = 32
) (
  input  wire                      clk,
  input  wire lkvc_pkg::cell_ctrl_t ctrl,
  input  wire                      valid,
  input  wire                      tail,
  input  wire  [KW-1:0]            cmp_key,
  input  wire  [KW-1:0]            prev_key,
  input  wire  [VW-1:0]            prev_val,
  output logic [KW-1:0]            key_q,
  output logic [VW-1:0]            val_q,
  output logic                     match,
  input  wire                      sfx_in,
  output logic                     sfx_out,
  input  wire  [VW-1:0]            rd_in,
  output logic [VW-1:0]            rd_out,
  input  wire  [KW-1:0]            ev_in,
  output logic [KW-1:0]            ev_out
);

  logic [KW-1:0] key_r, key_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic          en;
  logic [KW-1:0] tail_key;

  // compare and chain the hit down the row
  assign match   = valid & (key_r == cmp_key);
  assign sfx_out = match | sfx_in;
  assign rd_out  = rd_in | (match ? val_r : '0);

  // move when a new key goes in, or when the hit lies at or below this place
  assign en = ctrl.go & (ctrl.ins_all | sfx_out);

  // key that ends up at the least recent place
  assign tail_key = (ctrl.put_hit & sfx_out) ? prev_key : key_r;
  assign ev_out   = ev_in | (tail ? tail_key : '0);

  assign key_nxt = en ? prev_key : key_r;
  assign val_nxt = en ? prev_val : val_r;

  // entry storage
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign key_q = key_r;
  assign val_q = val_r;

endmodule

`default_nettype wire

/* sv/lru_key_value_cache_core.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// a result beat appears in the cycle after its input beat is taken
// throughput: one operation per cycle while no held result is stalled; the lookup,
//   hit chain and row move of all cells settle combinationally and the row updates at the accepting edge
// reset: synchronous rst_n empties the cache and sets capacity to 16
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_core_defines.svh"

module lru_key_value_cache_core #(
  parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire  [lkvc_pkg::CAP_W-1:0]   cfg_wdata,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  lkvc_pkg::in_item_t     in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output lkvc_pkg::out_item_t          out_data
);

  localparam int KW    = (KEY_BITS < lkvc_pkg::FIELD_W) ? KEY_BITS : lkvc_pkg::FIELD_W;
  localparam int VW    = (VALUE_BITS < lkvc_pkg::FIELD_W) ? VALUE_BITS : lkvc_pkg::FIELD_W;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

  logic [lkvc_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       out_valid_r, out_valid_nxt;
  lkvc_pkg::out_item_t        out_r, out_nxt;

  logic                       acc;
  logic                       is_put;
  logic                       found;
  logic [CMP_W-1:0]           cap_eff;
  logic [CMP_W-1:0]           cnt_ext;
  logic [KW-1:0]              key_in;
  logic [VW-1:0]              wval_in;
  lkvc_pkg::cell_ctrl_t       ctrl;
  logic                       evict;

  logic [KW-1:0]              key_q [MAX_ENTRIES];
  logic [VW-1:0]              val_q [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]     valid_v;
  logic [MAX_ENTRIES-1:0]     tail_v;
  logic [MAX_ENTRIES-1:0]     match_v;
  logic [MAX_ENTRIES:0]       sfx;
  logic [VW-1:0]              rd  [MAX_ENTRIES+1];
  logic [KW-1:0]              ev  [MAX_ENTRIES+1];

  // beat handshake: take a new beat unless a result is held and stalled
  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;

  assign key_in  = in_data.lookup_key[KW-1:0];
  assign wval_in = in_data.write_value[VW-1:0];
  assign is_put  = (in_data.kind == lkvc_pkg::KIND_PUT);

  // capacity clamped to 1 .. MAX_ENTRIES
  always_comb begin
    cap_eff = CMP_W'(cap_r);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end
  end
  assign cnt_ext = CMP_W'(count_r);

  // occupancy and least recent place, from the fill count
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid_v[i] = (CNT_W'(i) < count_r);
      tail_v[i]  = (CNT_W'(i + 1) == count_r);
    end
  end

  // chain ends
  assign sfx[MAX_ENTRIES] = 1'b0;
  assign rd[MAX_ENTRIES]  = '0;
  assign ev[MAX_ENTRIES]  = '0;
  assign found            = sfx[0];

  assign ctrl.go      = acc;
  assign ctrl.ins_all = is_put & ~found;
  assign ctrl.put_hit = is_put & found;

  // row of cells, most recent at place zero
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KW-1:0] pk;
    logic [VW-1:0] pv;
    if (i == 0) begin : g_head
      assign pk = key_in;
      assign pv = is_put ? wval_in : rd[0];
    end else begin : g_body
      assign pk = key_q[i-1];
      assign pv = val_q[i-1];
    end
    lkvc_cell #(
      .KW (KW),
      .VW (VW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .valid    (valid_v[i]),
      .tail     (tail_v[i]),
      .cmp_key  (key_in),
      .prev_key (pk),
      .prev_val (pv),
      .key_q    (key_q[i]),
      .val_q    (val_q[i]),
      .match    (match_v[i]),
      .sfx_in   (sfx[i+1]),
      .sfx_out  (sfx[i]),
      .rd_in    (rd[i+1]),
      .rd_out   (rd[i]),
      .ev_in    (ev[i+1]),
      .ev_out   (ev[i])
    );
  end

  // eviction: present key over capacity, or new key at capacity
  assign evict = is_put & (found ? (cnt_ext > cap_eff) : (cnt_ext >= cap_eff));

  // fill count and result
  always_comb begin
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (acc) begin
      if (is_put) begin
        if (found && evict) begin
          count_nxt = count_r - CNT_W'(1);
        end else if (!found && !evict) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      out_valid_nxt       = 1'b1;
      out_nxt.found       = found;
      out_nxt.read_value  = (!is_put && found) ? lkvc_pkg::FIELD_W'(rd[0]) : '0;
      out_nxt.evicted     = evict;
      out_nxt.evicted_key = evict ? lkvc_pkg::FIELD_W'(ev[0]) : '0;
    end
  end

  // capacity register
  assign cap_nxt = cfg_we ? cfg_wdata : cap_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= lkvc_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `LKVC_ASSERT_NOW(a_count_max, 1'b1, count_r <= CNT_W'(MAX_ENTRIES), "fill count over depth")
  `LKVC_ASSERT_NOW(a_one_match, 1'b1, $onehot0(match_v), "key held in more than one cell")
  `LKVC_ASSERT_NEXT(a_get_keeps, rst_n && acc && !is_put, count_r == $past(count_r), "get changed fill count")
  `LKVC_ASSERT_NEXT(a_put_grows, rst_n && acc && is_put && !found && !evict, count_r == $past(count_r) + CNT_W'(1), "insert without eviction did not grow fill count")
  `LKVC_ASSERT_NOW(a_evict_put, out_valid_r && out_r.evicted, out_r.read_value == '0, "eviction beat carries a read value")

endmodule

`default_nettype wire

/* tb/sv/tb_lru_key_value_cache_core.sv */
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_core
// self-checking bench for the lru key/value cache: a directed opening, then
// random put/get phases under several capacities, each beat checked against
// a recency-ordered list kept in step with every accepted operation
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int SLOTS      = MAX_ENTRIES_DEF;
  localparam int POOL_SIZE  = 24;
  localparam int PHASE_OPS  = 107;
  localparam int NUM_PHASES = 12;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 60;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CAP_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  // stimulus queue, expected beats and the recency list (front is most recent)
  in_item_t             ops_to_send[$];
  out_item_t            cache_replies_due[$];
  logic [FIELD_W-1:0]   lru_keys[$];
  logic [FIELD_W-1:0]   lru_vals[$];
  logic [CAP_W-1:0]     cap_model = CAP_RESET;

  logic [FIELD_W-1:0]   key_pool[POOL_SIZE];
  logic [FIELD_W-1:0]   last_key = '0;
  bit                   calm = 1'b0;
  int                   send_gap = 0;
  int                   stall_left = 0;
  int                   hold_left = 0;
  bit                   hold_done = 1'b0;
  int                   in_beats = 0;
  int                   fail_cnt = 0;
  int                   cycle_cnt = 0;

  lru_key_value_cache_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // gap length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one operation on the recency list, giving the beat it should produce
  function automatic out_item_t cache_access(in_item_t op);
    out_item_t          res;
    int                 hit_pos;
    int                 eff_cap;
    logic [FIELD_W-1:0] hit_val;
    res = '0;
    hit_pos = -1;
    eff_cap = (cap_model == 0) ? 1 : ((cap_model > SLOTS) ? SLOTS : int'(cap_model));
    for (int i = 0; i < lru_keys.size(); i++) begin
      if (hit_pos < 0 && lru_keys[i] == op.lookup_key) hit_pos = i;
    end
    res.found = (hit_pos >= 0);
    if (hit_pos >= 0) begin
      // hit: move to the front, a put also replaces the value
      hit_val = lru_vals[hit_pos];
      lru_keys.delete(hit_pos);
      lru_vals.delete(hit_pos);
      if (op.kind == KIND_GET) res.read_value = hit_val;
      else hit_val = op.write_value;
      lru_keys.push_front(op.lookup_key);
      lru_vals.push_front(hit_val);
      // a put hit trims one entry when capacity was lowered
      if (op.kind == KIND_PUT && lru_keys.size() > eff_cap) begin
        res.evicted = 1'b1;
        res.evicted_key = lru_keys.pop_back();
        void'(lru_vals.pop_back());
      end
    end else if (op.kind == KIND_PUT) begin
      // miss on put: make room if full, then insert as most recent
      if (lru_keys.size() >= eff_cap && lru_keys.size() != 0) begin
        res.evicted = 1'b1;
        res.evicted_key = lru_keys.pop_back();
        void'(lru_vals.pop_back());
      end
      lru_keys.push_front(op.lookup_key);
      lru_vals.push_front(op.write_value);
    end
    return res;
  endfunction

  function automatic void queue_op(logic kind, logic [FIELD_W-1:0] key,
                                   logic [FIELD_W-1:0] val);
    in_item_t op;
    op.kind = kind;
    op.lookup_key = key;
    op.write_value = val;
    ops_to_send.push_back(op);
  endfunction

  // random put/get, keys mostly from a small pool so hits are frequent
  function automatic void queue_random_op();
    int                 r;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] val;
    r = $urandom_range(0, 99);
    if (r < 20) key = last_key;
    else if (r < 88) key = key_pool[$urandom_range(0, POOL_SIZE-1)];
    else key = $urandom;
    r = $urandom_range(0, 99);
    if (r < 5) val = '0;
    else if (r < 10) val = '1;
    else val = $urandom;
    last_key = key;
    queue_op(($urandom_range(0, 1) == 1) ? KIND_GET : KIND_PUT, key, val);
  endfunction

  function automatic bit cache_busy();
    return ops_to_send.size() != 0 || in_valid || cache_replies_due.size() != 0;
  endfunction

  task automatic check_field(string name, logic [FIELD_W-1:0] want,
                             logic [FIELD_W-1:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("mismatch on %s at beat: expected %h, got %h", name, want, got);
    end
  endtask

  // input driver: holds the beat while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_valid && in_stall)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (ops_to_send.size() != 0) begin
        in_data <= ops_to_send.pop_front();
        in_valid <= 1'b1;
        send_gap = idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall: random gaps plus one long hold-off once the run is under way
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && in_beats >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_len();
    end
  end

  // monitor: predicts accepted beats and checks delivered ones
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cap_model <= CAP_RESET;
      lru_keys.delete();
      lru_vals.delete();
      cache_replies_due.delete();
    end else begin
      if (cfg_we) cap_model <= cfg_wdata;
      if (in_valid && !in_stall) begin
        cache_replies_due.push_back(cache_access(in_data));
        in_beats <= in_beats + 1;
      end
      if (out_valid && !out_stall) begin
        if (cache_replies_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected result beat: %p", out_data);
        end else begin
          want = cache_replies_due.pop_front();
          check_field("found", FIELD_W'(want.found), FIELD_W'(out_data.found));
          check_field("read_value", want.read_value, out_data.read_value);
          check_field("evicted", FIELD_W'(want.evicted), FIELD_W'(out_data.evicted));
          check_field("evicted_key", want.evicted_key, out_data.evicted_key);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("** lru_key_value_cache_core: FAILED **");
      $finish;
    end
  end

  // capacity per phase: the first lowers below a full cache, then extremes
  logic [CAP_W-1:0] phase_caps[8] = '{5'd3, 5'd0, 5'd1, 5'd31, 5'd16, 5'd8, 5'd2, 5'd30};

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int i = 0; i < SLOTS; i++) key_pool[i] = 100 + i;
    key_pool[POOL_SIZE-2] = '0;
    key_pool[POOL_SIZE-1] = '1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: miss on empty, extremes, put hit, ignored get value, eviction
    queue_op(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    queue_op(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_op(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(KIND_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_op(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_op(KIND_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
    queue_op(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    queue_op(KIND_GET, 32'h1234_5678, 32'hDEAD_BEEF);
    for (int i = 0; i < SLOTS; i++) queue_op(KIND_PUT, 100 + i, $urandom);
    queue_op(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      do @(negedge clk); while (cache_busy());
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= (p < 8) ? phase_caps[p] : CAP_W'($urandom_range(0, 31));
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      calm = (p % 3 == 2);
      for (int k = 0; k < PHASE_OPS; k++) queue_random_op();
    end

    // drain, then watch a little longer for stray beats
    do @(negedge clk); while (cache_busy());
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("** lru_key_value_cache_core: PASSED **");
    end else begin
      $display("** lru_key_value_cache_core: FAILED **");
    end
    $finish;
  end

endmodule
